// ===== rtl/core/bir_pkg.sv =====
// Package for the brace indent reformatter: character codes, microword format,
// the control store and the dispatch decoder. No dependencies.
package bir_pkg;

   localparam int INDENT_W = 4;
   localparam int BIR_MAX_INDENT = 15;
   localparam int PC_W = 6;

   localparam logic [7:0] CH_LBRACE = 8'd123;
   localparam logic [7:0] CH_RBRACE = 8'd125;
   localparam logic [7:0] CH_NL     = 8'd10;
   localparam logic [7:0] CH_SLASH  = 8'd47;
   localparam logic [7:0] CH_STAR   = 8'd42;
   localparam logic [7:0] CH_SPACE  = 8'd32;
   localparam logic [7:0] CH_TAB    = 8'd9;

   localparam logic [1:0] PEND_NONE  = 2'd0;
   localparam logic [1:0] PEND_SLASH = 2'd1;
   localparam logic [1:0] PEND_STAR  = 2'd2;

   // entry points and shared tails of the microprogram
   localparam logic [PC_W-1:0] A_CMT_OPEN   = 6'd0;
   localparam logic [PC_W-1:0] A_SLASH_RAW  = 6'd4;
   localparam logic [PC_W-1:0] A_CMT_CLOSE  = 6'd6;
   localparam logic [PC_W-1:0] A_STAR_RAW   = 6'd9;
   localparam logic [PC_W-1:0] A_DROP       = 6'd11;
   localparam logic [PC_W-1:0] A_HOLD_SLASH = 6'd12;
   localparam logic [PC_W-1:0] A_HOLD_STAR  = 6'd13;
   localparam logic [PC_W-1:0] A_LBRACE     = 6'd14;
   localparam logic [PC_W-1:0] A_NL_TAIL    = 6'd17;
   localparam logic [PC_W-1:0] A_RBRACE     = 6'd19;
   localparam logic [PC_W-1:0] A_NEWLINE    = 6'd23;
   localparam logic [PC_W-1:0] A_SPACE      = 6'd32;
   localparam logic [PC_W-1:0] A_OTHER      = 6'd34;

   typedef enum logic [1:0] {EM_NONE, EM_CONST, EM_BYTE, EM_TAB} emit_type;
   typedef enum logic [1:0] {J_NONE, J_ALWAYS, J_NCMT, J_NSEEN} jmp_type;
   typedef enum logic [1:0] {FL_KEEP, FL_SET, FL_CLR} flag_op_type;
   typedef enum logic [1:0] {IND_NONE, IND_INC, IND_DEC} ind_op_type;

   typedef struct packed {
      emit_type          emit;
      logic [7:0]        chr;
      logic              lz;      // last if indent is zero (a tab run follows)
      logic              fin;
      jmp_type           jmp;
      logic [PC_W-1:0]   target;
      logic              pend_wr;
      logic [1:0]        pend_val;
      flag_op_type       seen_op;
      flag_op_type       cmt_op;
      ind_op_type        ind_op;
   } uword_type;

   typedef struct packed {
      logic              upd;
      logic              emit;
      logic              last;
      emit_type          sel;
      logic [7:0]        chr;
      logic              pend_wr;
      logic [1:0]        pend_val;
      flag_op_type       seen_op;
      flag_op_type       cmt_op;
      ind_op_type        ind_op;
      logic              tab_hold;
      logic              tab_dec;
      logic              load_byte;
   } seq_ctl_type;

   typedef struct packed {
      logic [1:0]        pend;
      logic              cmt;
      logic              seen;
      logic              ind_zero;
      logic              tab_zero;
      logic              tab_one;
      logic              out_free;
   } dp_stat_type;

   function automatic uword_type uw(emit_type e, logic [7:0] c, logic lz, logic fin,
                                    jmp_type j, logic [PC_W-1:0] t, logic pw,
                                    logic [1:0] pv, flag_op_type so, flag_op_type co,
                                    ind_op_type io);
      uword_type w;
      w.emit = e;  w.chr = c;  w.lz = lz;  w.fin = fin;
      w.jmp = j;   w.target = t;
      w.pend_wr = pw;  w.pend_val = pv;
      w.seen_op = so;  w.cmt_op = co;  w.ind_op = io;
      return w;
   endfunction

   // control store
   function automatic uword_type rom_word(logic [PC_W-1:0] pc);
      uword_type w;
      unique case (pc)
         // comment open: NL, tabs, "/*"
         6'd0:  w = uw(EM_CONST, CH_NL, 1'b0, 1'b0, J_NONE, A_DROP, 1'b1, PEND_NONE,
                      FL_SET, FL_SET, IND_NONE);
         6'd1:  w = uw(EM_TAB, CH_TAB, 1'b0, 1'b0, J_NONE, A_DROP, 1'b0, PEND_NONE,
                      FL_KEEP, FL_KEEP, IND_NONE);
         6'd2:  w = uw(EM_CONST, CH_SLASH, 1'b0, 1'b0, J_NONE, A_DROP, 1'b0, PEND_NONE,
                      FL_KEEP, FL_KEEP, IND_NONE);
         6'd3:  w = uw(EM_CONST, CH_STAR, 1'b0, 1'b1, J_NONE, A_DROP, 1'b0, PEND_NONE,
                      FL_KEEP, FL_KEEP, IND_NONE);
         // held slash, passed raw
         6'd4:  w = uw(EM_CONST, CH_SLASH, 1'b0, 1'b0, J_NONE, A_DROP, 1'b1, PEND_NONE,
                      FL_SET, FL_KEEP, IND_NONE);
         6'd5:  w = uw(EM_BYTE, CH_TAB, 1'b0, 1'b1, J_NONE, A_DROP, 1'b0, PEND_NONE,
                      FL_KEEP, FL_KEEP, IND_NONE);
         // comment close: "*/" NL
         6'd6:  w = uw(EM_CONST, CH_STAR, 1'b0, 1'b0, J_NONE, A_DROP, 1'b1, PEND_NONE,
                      FL_SET, FL_CLR, IND_NONE);
         6'd7:  w = uw(EM_CONST, CH_SLASH, 1'b0, 1'b0, J_NONE, A_DROP, 1'b0, PEND_NONE,
                      FL_KEEP, FL_KEEP, IND_NONE);
         6'd8:  w = uw(EM_CONST, CH_NL, 1'b0, 1'b1, J_NONE, A_DROP, 1'b0, PEND_NONE,
                      FL_KEEP, FL_KEEP, IND_NONE);
         // held star, passed raw
         6'd9:  w = uw(EM_CONST, CH_STAR, 1'b0, 1'b0, J_NONE, A_DROP, 1'b1, PEND_NONE,
                      FL_SET, FL_KEEP, IND_NONE);
         6'd10: w = uw(EM_BYTE, CH_TAB, 1'b0, 1'b1, J_NONE, A_DROP, 1'b0, PEND_NONE,
                      FL_KEEP, FL_KEEP, IND_NONE);
         // no output
         6'd11: w = uw(EM_NONE, CH_TAB, 1'b0, 1'b1, J_NONE, A_DROP, 1'b1, PEND_NONE,
                      FL_KEEP, FL_KEEP, IND_NONE);
         6'd12: w = uw(EM_NONE, CH_TAB, 1'b0, 1'b1, J_NONE, A_DROP, 1'b1, PEND_SLASH,
                      FL_KEEP, FL_KEEP, IND_NONE);
         6'd13: w = uw(EM_NONE, CH_TAB, 1'b0, 1'b1, J_NONE, A_DROP, 1'b1, PEND_STAR,
                      FL_KEEP, FL_KEEP, IND_NONE);
         // open brace
         6'd14: w = uw(EM_CONST, CH_NL, 1'b0, 1'b0, J_NONE, A_DROP, 1'b1, PEND_NONE,
                      FL_KEEP, FL_KEEP, IND_NONE);
         6'd15: w = uw(EM_TAB, CH_TAB, 1'b0, 1'b0, J_NONE, A_DROP, 1'b0, PEND_NONE,
                      FL_KEEP, FL_KEEP, IND_NONE);
         6'd16: w = uw(EM_CONST, CH_LBRACE, 1'b0, 1'b0, J_NONE, A_DROP, 1'b0, PEND_NONE,
                      FL_KEEP, FL_KEEP, IND_INC);
         // shared tail: NL then tabs
         6'd17: w = uw(EM_CONST, CH_NL, 1'b1, 1'b0, J_NONE, A_DROP, 1'b0, PEND_NONE,
                      FL_KEEP, FL_KEEP, IND_NONE);
         6'd18: w = uw(EM_TAB, CH_TAB, 1'b0, 1'b1, J_NONE, A_DROP, 1'b0, PEND_NONE,
                      FL_KEEP, FL_KEEP, IND_NONE);
         // close brace: outdent first
         6'd19: w = uw(EM_NONE, CH_TAB, 1'b0, 1'b0, J_NONE, A_DROP, 1'b1, PEND_NONE,
                      FL_KEEP, FL_KEEP, IND_DEC);
         6'd20: w = uw(EM_CONST, CH_NL, 1'b0, 1'b0, J_NONE, A_DROP, 1'b0, PEND_NONE,
                      FL_KEEP, FL_KEEP, IND_NONE);
         6'd21: w = uw(EM_TAB, CH_TAB, 1'b0, 1'b0, J_NONE, A_DROP, 1'b0, PEND_NONE,
                      FL_KEEP, FL_KEEP, IND_NONE);
         6'd22: w = uw(EM_CONST, CH_RBRACE, 1'b0, 1'b0, J_ALWAYS, A_NL_TAIL, 1'b0,
                      PEND_NONE, FL_KEEP, FL_KEEP, IND_NONE);
         // newline; outside a comment it is just the tail
         6'd23: w = uw(EM_NONE, CH_TAB, 1'b0, 1'b0, J_NCMT, A_NL_TAIL, 1'b1, PEND_NONE,
                      FL_CLR, FL_KEEP, IND_NONE);
         6'd24: w = uw(EM_CONST, CH_SPACE, 1'b0, 1'b0, J_NONE, A_DROP, 1'b0, PEND_NONE,
                      FL_KEEP, FL_KEEP, IND_NONE);
         6'd25: w = uw(EM_CONST, CH_STAR, 1'b0, 1'b0, J_NONE, A_DROP, 1'b0, PEND_NONE,
                      FL_KEEP, FL_KEEP, IND_NONE);
         6'd26: w = uw(EM_CONST, CH_SLASH, 1'b0, 1'b0, J_NONE, A_DROP, 1'b0, PEND_NONE,
                      FL_KEEP, FL_KEEP, IND_NONE);
         6'd27: w = uw(EM_CONST, CH_NL, 1'b0, 1'b0, J_NONE, A_DROP, 1'b0, PEND_NONE,
                      FL_KEEP, FL_KEEP, IND_NONE);
         6'd28: w = uw(EM_TAB, CH_TAB, 1'b0, 1'b0, J_NONE, A_DROP, 1'b0, PEND_NONE,
                      FL_KEEP, FL_KEEP, IND_NONE);
         6'd29: w = uw(EM_CONST, CH_SLASH, 1'b0, 1'b0, J_NONE, A_DROP, 1'b0, PEND_NONE,
                      FL_KEEP, FL_KEEP, IND_NONE);
         6'd30: w = uw(EM_CONST, CH_STAR, 1'b0, 1'b0, J_NONE, A_DROP, 1'b0, PEND_NONE,
                      FL_KEEP, FL_KEEP, IND_NONE);
         6'd31: w = uw(EM_CONST, CH_SPACE, 1'b0, 1'b1, J_NONE, A_DROP, 1'b0, PEND_NONE,
                      FL_KEEP, FL_KEEP, IND_NONE);
         // space: dropped at the start of a line
         6'd32: w = uw(EM_NONE, CH_TAB, 1'b0, 1'b0, J_NSEEN, A_DROP, 1'b1, PEND_NONE,
                      FL_KEEP, FL_KEEP, IND_NONE);
         6'd33: w = uw(EM_CONST, CH_SPACE, 1'b0, 1'b1, J_NONE, A_DROP, 1'b0, PEND_NONE,
                      FL_KEEP, FL_KEEP, IND_NONE);
         6'd34: w = uw(EM_BYTE, CH_TAB, 1'b0, 1'b1, J_NONE, A_DROP, 1'b1, PEND_NONE,
                      FL_SET, FL_KEEP, IND_NONE);
         default: w = uw(EM_NONE, CH_TAB, 1'b0, 1'b1, J_NONE, A_DROP, 1'b0, PEND_NONE,
                         FL_KEEP, FL_KEEP, IND_NONE);
      endcase
      return w;
   endfunction

   // dispatch: program entry for a new byte given the held prefix
   function automatic logic [PC_W-1:0] entry_pc(logic [1:0] pend, logic [7:0] c);
      logic [PC_W-1:0] pc;
      if (pend == PEND_SLASH) begin
         pc = (c == CH_STAR) ? A_CMT_OPEN : A_SLASH_RAW;
      end else if (pend == PEND_STAR) begin
         pc = (c == CH_SLASH) ? A_CMT_CLOSE : A_STAR_RAW;
      end else begin
         unique case (c)
            CH_TAB:    pc = A_DROP;
            CH_LBRACE: pc = A_LBRACE;
            CH_RBRACE: pc = A_RBRACE;
            CH_NL:     pc = A_NEWLINE;
            CH_SLASH:  pc = A_HOLD_SLASH;
            CH_STAR:   pc = A_HOLD_STAR;
            CH_SPACE:  pc = A_SPACE;
            default:   pc = A_OTHER;
         endcase
      end
      return pc;
   endfunction

endpackage

// ===== rtl/core/bir_if.sv =====
// Valid/ready channel interfaces for the reformatter's request and response sides.
// Depends on nothing.
interface bir_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

interface bir_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last;

   modport source (output valid, output out_byte, output last, input ready);
   modport sink   (input valid, input out_byte, input last, output ready);
endinterface

// ===== rtl/core/bir_seq.sv =====
// Microcode sequencer: step counter, control store lookup, dispatch and jumps.
// Depends on bir_pkg.
module bir_seq (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [7:0]           req_byte,
   input  bir_pkg::dp_stat_type stat,
   output bir_pkg::seq_ctl_type ctl
);
   import bir_pkg::*;

   logic              busy_ff, busy_in;
   logic [PC_W-1:0]   pc_ff, pc_in;
   uword_type         w;
   logic              is_tab, emits, go, done, taken, accept;

   always_comb begin
      w      = rom_word(pc_ff);
      is_tab = (w.emit == EM_TAB);
      emits  = is_tab ? !stat.tab_zero : (w.emit != EM_NONE);
      go     = busy_ff && (!emits || stat.out_free);
      // a tab step repeats until its count runs out
      done   = !is_tab || stat.tab_zero || stat.tab_one;
      accept = req_valid && !busy_ff;
      unique case (w.jmp)
         J_NONE:   taken = 1'b0;
         J_ALWAYS: taken = 1'b1;
         J_NCMT:   taken = !stat.cmt;
         J_NSEEN:  taken = !stat.seen;
         default:  taken = 1'b0;
      endcase

      busy_in = busy_ff;
      pc_in   = pc_ff;
      if (accept) begin
         busy_in = 1'b1;
         pc_in   = entry_pc(stat.pend, req_byte);
      end else if (go && done) begin
         if (w.fin) begin
            busy_in = 1'b0;
         end else begin
            pc_in = taken ? w.target : pc_ff + 1'b1;
         end
      end

      ctl.upd       = go && !is_tab;
      ctl.emit      = go && emits;
      ctl.last      = is_tab ? (w.fin && stat.tab_one) : (w.fin || (w.lz && stat.ind_zero));
      ctl.sel       = w.emit;
      ctl.chr       = w.chr;
      ctl.pend_wr   = w.pend_wr;
      ctl.pend_val  = w.pend_val;
      ctl.seen_op   = w.seen_op;
      ctl.cmt_op    = w.cmt_op;
      ctl.ind_op    = w.ind_op;
      ctl.tab_hold  = busy_ff && is_tab;
      ctl.tab_dec   = go && is_tab && !stat.tab_zero;
      ctl.load_byte = accept;
   end

   assign req_ready = !busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pc_ff   <= A_DROP;
      end else begin
         busy_ff <= busy_in;
         pc_ff   <= pc_in;
      end
   end

endmodule

// ===== rtl/core/bir_dp.sv =====
// Datapath: indent, comment and prefix state, tab counter and the response register.
// Depends on bir_pkg; driven by the control word from bir_seq.
module bir_dp #(
   parameter int MAX_INDENT = bir_pkg::BIR_MAX_INDENT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [7:0]           req_byte,
   input  bir_pkg::seq_ctl_type ctl,
   output bir_pkg::dp_stat_type stat,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [7:0]           rsp_byte,
   output logic                 rsp_last
);
   import bir_pkg::*;

   localparam int FullScale = (1 << INDENT_W) - 1;
   localparam logic [INDENT_W-1:0] IndentCap =
      INDENT_W'((MAX_INDENT < FullScale) ? MAX_INDENT : FullScale);

   logic [INDENT_W-1:0] indent_ff, indent_in;
   logic [INDENT_W-1:0] tcnt_ff, tcnt_in;
   logic                cmt_ff, cmt_in;
   logic                seen_ff, seen_in;
   logic [1:0]          pend_ff, pend_in;
   logic [7:0]          byte_ff, byte_in;
   logic                out_valid_ff, out_valid_in;
   logic [7:0]          out_byte_ff, out_byte_in;
   logic                out_last_ff, out_last_in;
   logic                out_free;

   always_comb begin
      out_free  = !out_valid_ff || rsp_ready;
      indent_in = indent_ff;
      cmt_in    = cmt_ff;
      seen_in   = seen_ff;
      pend_in   = pend_ff;
      if (ctl.upd) begin
         if (ctl.pend_wr) pend_in = ctl.pend_val;
         case (ctl.seen_op)
            FL_SET:  seen_in = 1'b1;
            FL_CLR:  seen_in = 1'b0;
            default: seen_in = seen_ff;
         endcase
         case (ctl.cmt_op)
            FL_SET:  cmt_in = 1'b1;
            FL_CLR:  cmt_in = 1'b0;
            default: cmt_in = cmt_ff;
         endcase
         case (ctl.ind_op)
            IND_INC: if (indent_ff < IndentCap) indent_in = indent_ff + 1'b1;
            IND_DEC: if (indent_ff != '0) indent_in = indent_ff - 1'b1;
            default: indent_in = indent_ff;
         endcase
      end

      // counter tracks the indent until a tab run starts counting it down
      if (!ctl.tab_hold) begin
         tcnt_in = indent_ff;
      end else if (ctl.tab_dec) begin
         tcnt_in = tcnt_ff - 1'b1;
      end else begin
         tcnt_in = tcnt_ff;
      end

      byte_in = ctl.load_byte ? req_byte : byte_ff;

      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      if (ctl.emit) begin
         out_valid_in = 1'b1;
         out_last_in  = ctl.last;
         case (ctl.sel)
            EM_BYTE: out_byte_in = byte_ff;
            EM_TAB:  out_byte_in = CH_TAB;
            default: out_byte_in = ctl.chr;
         endcase
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end

      stat.pend     = pend_ff;
      stat.cmt      = cmt_ff;
      stat.seen     = seen_ff;
      stat.ind_zero = (indent_ff == '0);
      stat.tab_zero = (tcnt_ff == '0);
      stat.tab_one  = (tcnt_ff == INDENT_W'(1));
      stat.out_free = out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         indent_ff    <= '0;
         cmt_ff       <= 1'b0;
         seen_ff      <= 1'b0;
         pend_ff      <= PEND_NONE;
         tcnt_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         indent_ff    <= indent_in;
         cmt_ff       <= cmt_in;
         seen_ff      <= seen_in;
         pend_ff      <= pend_in;
         tcnt_ff      <= tcnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff     <= byte_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_byte  = out_byte_ff;
   assign rsp_last  = out_last_ff;

endmodule

// ===== rtl/core/brace_indent_reformatter_top.sv =====
// Top level of the brace indent reformatter: sequencer plus datapath.
// Depends on bir_pkg, bir_if, bir_seq and bir_dp.
//
// Reformats a source-text byte stream: tabs and leading spaces are dropped, braces go
// on their own lines with the indent stepped (saturating at 0 and at the smaller of
// MAX_INDENT and 15), newlines re-indent with tabs and close/reopen an open comment,
// and a slash or star is held one request to spot a comment open or close. One request
// is taken at a time; req_if.ready returns when the microprogram for it has finished.
// The microprogram issues at most one response byte per cycle, stalling while a
// response byte waits on rsp_if.ready. A request is dispatched and then runs its program
// steps in order, with each tab of an indent run taking its own step and an empty tab
// run still taking one step. The last response byte for a request carries last;
// requests that produce nothing (tab, held prefix, leading space) finish without a
// response. The response register lets the next request in while the final byte
// still waits on rsp_if.ready.
module brace_indent_reformatter_top #(
   parameter int MAX_INDENT = bir_pkg::BIR_MAX_INDENT
) (
   input logic     clock,
   input logic     reset,
   bir_req_if.sink   req_if,
   bir_rsp_if.source rsp_if
);
   import bir_pkg::*;

   seq_ctl_type ctl;
   dp_stat_type stat;

   bir_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .req_byte  (req_if.in_byte),
      .stat      (stat),
      .ctl       (ctl)
   );

   bir_dp #(
      .MAX_INDENT (MAX_INDENT)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_byte  (req_if.in_byte),
      .ctl       (ctl),
      .stat      (stat),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .rsp_byte  (rsp_if.out_byte),
      .rsp_last  (rsp_if.last)
   );

endmodule

// ===== rtl/core/bir_check.sv =====
// Port-level checks for the reformatter top, attached by the bind at the end.
// Depends on brace_indent_reformatter_top and bir_if.
module bir_check (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_byte,
   input logic       rsp_last
);

   // a stalled response holds its byte and flag
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_byte) && $stable(rsp_last))
      else $error("response changed while stalled");

   // only one request in flight
   a_one_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while the previous one is in flight");

   // when idle, any waiting response must close its run
   a_idle_last: assert property (@(posedge clock) disable iff (reset)
      req_ready && rsp_valid |-> rsp_last)
      else $error("idle with an unterminated response run");

   // the sequencer is idle right after reset
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) && !reset |-> req_ready && !rsp_valid)
      else $error("not idle after reset");

endmodule

bind brace_indent_reformatter_top bir_check u_bir_check (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_if.valid),
   .req_ready (req_if.ready),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready),
   .rsp_byte  (rsp_if.out_byte),
   .rsp_last  (rsp_if.last)
);
